[hdl/d2h_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2h_pkg
// Shared types and constants of the binary64 to hex-float converter.
// ----------------------------------------------------------------------------
package d2h_pkg;

   localparam logic [6:0] START_EXP = 7'd80;
   localparam logic [6:0] MAX_EXP   = 7'h7F;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

   typedef struct packed {
      logic [63:0] value_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] real_bits;
      logic        overflow;
   } rsp_type;

   // state carried between the normalizing stages
   typedef struct packed {
      logic         sign;
      logic         zero;
      logic         ovf;
      logic [127:0] fix;
      logic [6:0]   expo;
   } work_type;

endpackage

[hdl/d2h_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2h_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface d2h_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/d2h_unpack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2h_unpack
// Decode the binary64 pattern and align the magnitude to 64.64 fixed point.
// ----------------------------------------------------------------------------
module d2h_unpack (
   input  logic              [63:0] value_bits,
   output d2h_pkg::work_type        work
);
   logic [10:0]  bexp;
   logic [51:0]  frac;
   logic [52:0]  sig;
   logic [11:0]  sh;
   logic [127:0] wide;

   // magnitude = sig * 2^(bexp-1075); fix = sig << (bexp-1075+64)
   always_comb begin
      bexp = value_bits[62:52];
      frac = value_bits[51:0];
      sig  = (bexp == 11'd0) ? {1'b0, frac} : {1'b1, frac};
      work.sign = value_bits[63];
      work.zero = (bexp == 11'd0) && (frac == 52'd0);
      work.ovf  = (bexp == d2h_pkg::EXP_ALL_ONES) || (bexp >= 11'd1087);
      work.expo = d2h_pkg::START_EXP;
      wide      = {75'd0, sig};
      sh        = {1'b0, (bexp == 11'd0) ? 11'd1 : bexp};
      if (sh >= 12'd1011) begin
         work.fix = wide << (sh - 12'd1011);
      end else begin
         work.fix = wide >> (12'd1011 - sh);
      end
   end
endmodule

[hdl/d2h_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2h_norm
// One normalize step: shift out up to four leading zero nibbles.
// ----------------------------------------------------------------------------
module d2h_norm (
   input  d2h_pkg::work_type work_i,
   output d2h_pkg::work_type work_o
);
   logic [2:0] step;

   always_comb begin
      work_o = work_i;
      for (step = 3'd0; step < 3'd4; step = step + 3'd1) begin
         if (work_o.fix[127:124] == 4'd0) begin
            work_o.fix  = work_o.fix << 4;
            work_o.expo = work_o.expo - 7'd1;
         end
      end
   end
endmodule

[hdl/double_to_hex_float_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_hex_float_converter
// Binary64 pattern in, 8-byte excess-64 base-16 real and overflow flag out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries value_bits, rsp carries real_bits and overflow; both are
//   valid/ready channels, an item moves when valid and ready are high.
//   The pipeline has five register stages: unpack/align, then four
//   normalize stages of up to four nibble shifts each (16 in all).
//   Throughput is one item per cycle unless rsp stalls. Each stage
//   advances when the stage after it is empty or moving, so a stall on
//   rsp holds every stage in place and req_ready drops only once the
//   whole pipeline is full.
//   Zero of either sign gives 0. Magnitudes of 2^64 or more, infinities
//   and NaNs give the largest magnitude with the input sign and overflow.
//   Reset empties the pipeline; no item is in flight afterward.
// ----------------------------------------------------------------------------
module double_to_hex_float_converter (
   input logic clock,
   input logic reset,
   d2h_if.sink   req,
   d2h_if.source rsp
);
   localparam int NSTG = 5;

   d2h_pkg::work_type stage_ff [NSTG];
   d2h_pkg::work_type stage_in [NSTG];
   logic [NSTG-1:0]   valid_ff;
   logic [NSTG-1:0]   move;
   d2h_pkg::work_type first;
   d2h_pkg::work_type last;

   d2h_unpack u_unpack (.value_bits(req.payload.value_bits), .work(first));

   assign stage_in[0] = first;
   for (genvar g = 1; g < NSTG; g++) begin : g_norm
      d2h_norm u_norm (.work_i(stage_ff[g-1]), .work_o(stage_in[g]));
   end

   always_comb begin
      move[NSTG-1] = !valid_ff[NSTG-1] || rsp.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         move[i] = !valid_ff[i] || move[i+1];
      end
   end

   assign req.ready = move[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (move[0]) begin
            valid_ff[0] <= req.valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (move[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
      for (int i = 0; i < NSTG; i++) begin
         if (move[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   always_comb begin
      last = stage_ff[NSTG-1];
      rsp.valid = valid_ff[NSTG-1];
      rsp.payload.overflow = last.ovf;
      if (last.ovf) begin
         rsp.payload.real_bits = {last.sign, d2h_pkg::MAX_EXP, {56{1'b1}}};
      end else if (last.zero) begin
         rsp.payload.real_bits = '0;
      end else begin
         rsp.payload.real_bits = {last.sign, last.expo, last.fix[127:72]};
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result changed while stalled");
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> valid_ff == '1)
      else $error("input stalled with a bubble inside");
   a_ovf_exp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.overflow |-> rsp.payload.real_bits[62:56] == d2h_pkg::MAX_EXP)
      else $error("overflow without saturated exponent");
endmodule
